>>> hdl/hcbd_pkg.sv
// Shared types, character codes and decode helpers for the chunked body decoder.
package hcbd_pkg;

    // Result kinds carried on the output channel.
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_TERM  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_EARLY = 2'd3
    } kind_t;

    // One classified input byte as it waits between the parser and the output stage.
    typedef struct packed {
        logic       has_pri;
        logic [7:0] pri_byte;
        kind_t      pri_kind;
        logic       has_early;
    } hcbd_item_t;

    // Queue between the parser and the output stage.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Character codes.
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_X_LO  = 8'h78;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Whitespace that may lead a size line.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
               (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
    endfunction

endpackage

>>> hdl/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked body decoder.
//
//   Channel   Handshake            Beat contents
//   rx        rx_valid/rx_ready    in_byte, body_end
//   tx        tx_valid/tx_ready    out_byte, kind, last
//
// The parser takes one body byte per cycle while rx_ready is high; a byte that causes a
// result is written to a queue slot at the edge that accepts it and then moves on to the
// output register that drives tx. A byte with two results (data plus early end) gives two beats.
// Reset clears all control state at once; no clearing pass is needed.
// While tx_ready is low the four-entry queue fills and then rx_ready drops.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] in_byte,
    input  logic       body_end,
    output logic       tx_valid,
    input  logic       tx_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last
);
    import hcbd_pkg::*;

    logic       accept;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    hcbd_item_t push_item;
    hcbd_item_t head;
    kind_t      kind_q;

    assign rx_ready = !full;
    assign accept   = rx_valid && rx_ready;

    hcbd_front #(
        .SIZE_BITS(SIZE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .body_end (body_end),
        .push     (push),
        .item     (push_item)
    );

    hcbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    hcbd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .tx_ready (tx_ready),
        .tx_valid (tx_valid),
        .out_byte (out_byte),
        .kind     (kind_q),
        .last     (last)
    );

    assign kind = kind_q;

endmodule

>>> hdl/hcbd_front.sv
// Front end: parses one body byte per cycle while accept is high and classifies the results it causes.
module hcbd_front #(
    parameter int SIZE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                body_end,
    output logic                push,
    output hcbd_pkg::hcbd_item_t item
);
    import hcbd_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_DIGITS  = 3'd1,
        PH_TAIL    = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRAILER = 3'd4,
        PH_DROP    = 3'd5
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic                 cr_reg, cr_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [3:0]           digit_reg, digit_next;
    logic [SIZE_BITS-1:0] owed_reg, owed_next;
    logic                 prefix_reg, prefix_next;

    logic                 consumed;
    logic                 lf_done;
    logic                 go_bad;
    logic                 pri_v;
    logic [7:0]           pri_byte;
    kind_t                pri_kind;
    logic                 early;
    logic [4:0]           hex;

    assign hex = hex_decode(in_byte);

    // Next-state logic for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        cr_next     = cr_reg;
        size_next   = size_reg;
        digit_next  = digit_reg;
        owed_next   = owed_reg;
        prefix_next = prefix_reg;
        consumed    = 1'b0;
        lf_done     = 1'b0;
        go_bad      = 1'b0;
        pri_v       = 1'b0;
        pri_byte    = 8'd0;
        pri_kind    = KIND_DATA;
        early       = 1'b0;

        // After a chunk's data, swallow one CRLF if it is there.
        if (phase_reg == PH_TRAILER)
        begin
            if (cr_reg)
            begin
                cr_next    = 1'b0;
                phase_next = PH_LEAD;
                consumed   = (in_byte == CHAR_LF);
            end
            else if (in_byte == CHAR_CR)
            begin
                cr_next  = 1'b1;
                consumed = 1'b1;
            end
            else
            begin
                phase_next = PH_LEAD;
            end
        end

        if (!consumed)
        begin
            unique case (phase_next) inside
                PH_LEAD, PH_DIGITS, PH_TAIL:
                begin
                    // A pending CR either completes the line or is dropped.
                    if (cr_next)
                    begin
                        cr_next = 1'b0;
                        if (in_byte == CHAR_LF)
                        begin
                            lf_done = 1'b1;
                            if (digit_next == 4'd0)
                            begin
                                go_bad = 1'b1;
                            end
                            else if (size_next == '0)
                            begin
                                pri_v      = 1'b1;
                                pri_kind   = KIND_TERM;
                                phase_next = PH_DROP;
                            end
                            else
                            begin
                                owed_next  = size_next;
                                phase_next = PH_DATA;
                            end
                            size_next   = '0;
                            digit_next  = 4'd0;
                            prefix_next = 1'b0;
                        end
                        else if (phase_next == PH_DIGITS)
                        begin
                            phase_next = PH_TAIL;
                        end
                    end

                    if (!lf_done)
                    begin
                        if (in_byte == CHAR_CR)
                        begin
                            cr_next = 1'b1;
                        end
                        else if (phase_next == PH_LEAD)
                        begin
                            if (hex[4])
                            begin
                                size_next  = {size_next[SIZE_BITS-5:0], hex[3:0]};
                                digit_next = 4'd1;
                                phase_next = PH_DIGITS;
                            end
                            else if (!is_space(in_byte))
                            begin
                                go_bad = 1'b1;
                            end
                        end
                        else if (phase_next == PH_DIGITS)
                        begin
                            if (hex[4])
                            begin
                                // A digit that needs more than SIZE_BITS bits is a bad size.
                                if (size_next[SIZE_BITS-1 -: 4] != 4'd0)
                                begin
                                    go_bad = 1'b1;
                                end
                                else
                                begin
                                    size_next = {size_next[SIZE_BITS-5:0], hex[3:0]};
                                    if (digit_next != 4'hF)
                                    begin
                                        digit_next = digit_next + 4'd1;
                                    end
                                end
                            end
                            else if ((in_byte == CHAR_X_LO || in_byte == CHAR_X_UP) &&
                                     !prefix_next && digit_next == 4'd1 && size_next == '0)
                            begin
                                prefix_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_TAIL;
                            end
                        end
                    end

                    if (go_bad)
                    begin
                        pri_v       = 1'b1;
                        pri_kind    = KIND_BAD;
                        phase_next  = PH_DROP;
                        cr_next     = 1'b0;
                        size_next   = '0;
                        digit_next  = 4'd0;
                        prefix_next = 1'b0;
                    end
                end
                PH_DATA:
                begin
                    pri_v    = 1'b1;
                    pri_byte = in_byte;
                    if (owed_reg != '0)
                    begin
                        owed_next = owed_reg - 1'b1;
                    end
                    if (owed_reg <= SIZE_BITS'(1))
                    begin
                        phase_next = PH_TRAILER;
                        cr_next    = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // The last body byte resets the parser; it reports an early end unless in PH_DROP.
        if (body_end)
        begin
            early       = (phase_next != PH_DROP);
            phase_next  = PH_LEAD;
            cr_next     = 1'b0;
            size_next   = '0;
            digit_next  = 4'd0;
            owed_next   = '0;
            prefix_next = 1'b0;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEAD;
            cr_reg     <= 1'b0;
            size_reg   <= '0;
            digit_reg  <= 4'd0;
            owed_reg   <= '0;
            prefix_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            cr_reg     <= cr_next;
            size_reg   <= size_next;
            digit_reg  <= digit_next;
            owed_reg   <= owed_next;
            prefix_reg <= prefix_next;
        end
    end

    // Only bytes that cause a result enter the queue.
    assign push           = accept && (pri_v || early);
    assign item.has_pri   = pri_v;
    assign item.pri_byte  = pri_byte;
    assign item.pri_kind  = pri_kind;
    assign item.has_early = early;

endmodule

>>> hdl/hcbd_queue.sv
// Short queue of classified bytes between the parser and the output stage.
module hcbd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hcbd_pkg::hcbd_item_t push_item,
    input  logic                 pop,
    output logic                 full,
    output logic                 empty,
    output hcbd_pkg::hcbd_item_t head
);
    import hcbd_pkg::*;

    hcbd_item_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/hcbd_back.sv
// Back end: expands each queued byte into one or two result beats in an output register.
module hcbd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcbd_pkg::hcbd_item_t head,
    input  logic                 empty,
    output logic                 pop,
    input  logic                 tx_ready,
    output logic                 tx_valid,
    output logic [7:0]           out_byte,
    output hcbd_pkg::kind_t      kind,
    output logic                 last
);
    import hcbd_pkg::*;

    logic        valid_reg, valid_next;
    logic        sub_reg, sub_next;
    logic [7:0]  byte_reg, byte_next;
    kind_t       kind_reg, kind_next;
    logic        last_reg, last_next;
    logic        load;
    logic        send_pri;

    // The output register takes a new beat when it is empty or being drained.
    assign load     = !valid_reg || tx_ready;
    assign send_pri = head.has_pri && !sub_reg;

    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (send_pri)
                begin
                    byte_next = head.pri_byte;
                    kind_next = head.pri_kind;
                    last_next = !head.has_early;
                    sub_next  = head.has_early;
                    pop       = !head.has_early;
                end
                else
                begin
                    byte_next = 8'd0;
                    kind_next = KIND_EARLY;
                    last_next = 1'b1;
                    sub_next  = 1'b0;
                    pop       = 1'b1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    // Beat payload.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign tx_valid = valid_reg;
    assign out_byte = byte_reg;
    assign kind     = kind_reg;
    assign last     = last_reg;

endmodule

>>> tb/sv/http_chunked_body_decoder_test.sv
// Testbench for the chunked body decoder: directed and random bodies checked beat by beat.
`timescale 1ns / 1ps

module http_chunked_body_decoder_test;
    import hcbd_pkg::*;

    localparam int SZ          = 32;
    localparam int CLK_HALF    = 6;
    localparam int RAND_BYTES  = 1600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_LEN    = 200;
    localparam int TAIL_CYCLES = 20;
    localparam int SHOW_MAX    = 10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Parse position of the local decoder.
    typedef enum logic [2:0] {
        LINE_LEAD,
        LINE_DIGITS,
        LINE_TAIL,
        IN_DATA,
        IN_TRAILER,
        SKIP_REST
    } parse_t;

    // One body byte waiting to be sent.
    typedef struct {
        logic [7:0] b;
        logic       fin;
        logic       sync;
    } body_byte_t;

    // One decoded beat as it should appear on the output.
    typedef struct {
        logic [7:0] b;
        kind_t      k;
        logic       l;
    } out_beat_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] in_byte  = 8'h00;
    logic       body_end = 1'b0;
    logic       tx_valid;
    logic       tx_ready = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    body_byte_t pending[$];
    logic [7:0] body_buf[$];
    out_beat_t  step_out[$];
    out_beat_t  decoded_due[$];

    int accepted_cnt = 0;
    int mismatches   = 0;
    int cycles       = 0;
    int rx_gap       = 0;
    int rx_burst     = 0;
    int tx_wait      = 0;
    int tx_burst     = 0;
    logic hold_done  = 1'b0;

    // Local decoder state.
    parse_t          ph;
    logic            cr_seen;
    logic [SZ-1:0]   sz_acc;
    logic [3:0]      ndig;
    logic [SZ-1:0]   owed;
    logic            pfx;

    http_chunked_body_decoder #(
        .SIZE_BITS(SZ)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .in_byte  (in_byte),
        .body_end (body_end),
        .tx_valid (tx_valid),
        .tx_ready (tx_ready),
        .out_byte (out_byte),
        .kind     (kind),
        .last     (last)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Value of a hex digit, or -1 for any other byte.
    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
               c == CHAR_FF || c == CHAR_CR;
    endfunction

    task automatic clear_line();
        cr_seen = 1'b0;
        sz_acc  = '0;
        ndig    = 4'd0;
        pfx     = 1'b0;
    endtask

    task automatic reset_model();
        ph   = LINE_LEAD;
        owed = '0;
        clear_line();
    endtask

    task automatic emit(input logic [7:0] val, input kind_t kd);
        step_out.push_back('{b: val, k: kd, l: 1'b0});
    endtask

    task automatic reject_line();
        emit(8'h00, KIND_BAD);
        ph = SKIP_REST;
        clear_line();
    endtask

    // One byte of a size line: leading blanks, digits, or the ignored tail.
    task automatic take_line_byte(input logic [7:0] c);
        int d;
        d = hex_value(c);
        if (cr_seen)
        begin
            cr_seen = 1'b0;
            if (c == CHAR_LF)
            begin
                if (ndig == 4'd0)
                begin
                    reject_line();
                end
                else
                begin
                    if (sz_acc == '0)
                    begin
                        emit(8'h00, KIND_TERM);
                        ph = SKIP_REST;
                    end
                    else
                    begin
                        owed = sz_acc;
                        ph   = IN_DATA;
                    end
                    clear_line();
                end
                return;
            end
            if (ph == LINE_DIGITS)
                ph = LINE_TAIL;
        end
        if (c == CHAR_CR)
        begin
            cr_seen = 1'b1;
        end
        else if (ph == LINE_LEAD)
        begin
            if (d >= 0)
            begin
                sz_acc = SZ'(d);
                ndig   = 4'd1;
                ph     = LINE_DIGITS;
            end
            else if (!blank(c))
            begin
                reject_line();
            end
        end
        else if (ph == LINE_DIGITS)
        begin
            if (d >= 0)
            begin
                // A digit that would push bits out of the size register is a bad line.
                if (sz_acc[SZ-1 -: 4] != 4'd0)
                begin
                    reject_line();
                end
                else
                begin
                    sz_acc = {sz_acc[SZ-5:0], 4'(d)};
                    if (ndig != 4'd15)
                        ndig = ndig + 4'd1;
                end
            end
            else if ((c == CHAR_X_LO || c == CHAR_X_UP) && !pfx && ndig == 4'd1 &&
                     sz_acc == '0)
            begin
                pfx = 1'b1;
            end
            else
            begin
                ph = LINE_TAIL;
            end
        end
    endtask

    // Works out the beats one accepted byte causes and queues them.
    task automatic decode_byte(input logic [7:0] c, input logic fin);
        logic used;
        used = 1'b0;
        step_out.delete();
        // The CRLF after chunk data is swallowed; anything else opens the next size line.
        if (ph == IN_TRAILER)
        begin
            if (cr_seen)
            begin
                cr_seen = 1'b0;
                ph      = LINE_LEAD;
                used    = (c == CHAR_LF);
            end
            else if (c == CHAR_CR)
            begin
                cr_seen = 1'b1;
                used    = 1'b1;
            end
            else
            begin
                ph = LINE_LEAD;
            end
        end
        if (!used)
        begin
            if (ph == LINE_LEAD || ph == LINE_DIGITS || ph == LINE_TAIL)
            begin
                take_line_byte(c);
            end
            else if (ph == IN_DATA)
            begin
                emit(c, KIND_DATA);
                if (owed != '0)
                    owed = owed - 1'b1;
                if (owed == '0)
                begin
                    ph      = IN_TRAILER;
                    cr_seen = 1'b0;
                end
            end
        end
        // End of body before a status closes it early.
        if (fin)
        begin
            if (ph != SKIP_REST)
                emit(8'h00, KIND_EARLY);
            reset_model();
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].l = 1'b1;
        foreach (step_out[i])
            decoded_due.push_back(step_out[i]);
    endtask

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_LF;
            3: return CHAR_VT;
            4: return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            body_buf.push_back(s[i]);
    endtask

    task automatic put_crlf();
        body_buf.push_back(CHAR_CR);
        body_buf.push_back(CHAR_LF);
    endtask

    // Hex digit in either case.
    task automatic put_hex(input logic [3:0] nib);
        logic [7:0] base;
        if (nib < 4'd10)
        begin
            body_buf.push_back(CHAR_ZERO + 8'(nib));
        end
        else
        begin
            base = $urandom_range(0, 1) ? "A" : "a";
            body_buf.push_back(base + 8'(nib) - 8'd10);
        end
    endtask

    // A size line with optional blanks, prefix, leading zeros and extension.
    task automatic put_size_line(input logic [31:0] n);
        int nd;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) body_buf.push_back(pick_blank());
        if ($urandom_range(0, 4) == 0)
        begin
            body_buf.push_back(CHAR_ZERO);
            body_buf.push_back($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(14, 17) : $urandom_range(1, 3))
                body_buf.push_back(CHAR_ZERO);
        nd = 1;
        while (nd < 8 && (n >> (4 * nd)) != 0)
            nd++;
        for (int i = nd - 1; i >= 0; i--)
            put_hex(4'(n >> (4 * i)));
        if ($urandom_range(0, 3) == 0)
        begin
            body_buf.push_back($urandom_range(0, 1) ? CHAR_SEMI : CHAR_SPACE);
            repeat ($urandom_range(0, 6)) body_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        put_crlf();
    endtask

    // One chunk: size line, data, and usually its CRLF.
    task automatic put_chunk();
        int len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(1, 8);
        else if (r < 96)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(41, 200);
        put_size_line(len);
        repeat (len) body_buf.push_back(8'($urandom()));
        r = $urandom_range(0, 99);
        if (r < 85)
            put_crlf();
        else if (r < 92)
            body_buf.push_back(CHAR_CR);
        else if (r < 96)
            body_buf.push_back(CHAR_LF);
    endtask

    // A size line that must be rejected.
    task automatic put_bad_line();
        case ($urandom_range(0, 3))
            0:
            begin
                if ($urandom_range(0, 1))
                    body_buf.push_back(pick_blank());
                body_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                put_hex(4'($urandom()));
            end
            1: body_buf.push_back(8'($urandom_range(8'h67, 8'h7A)));
            2: put_crlf();
            default:
            begin
                put_hex(4'($urandom_range(1, 15)));
                repeat ($urandom_range(8, 10)) put_hex(4'($urandom()));
            end
        endcase
    endtask

    // A random body: mostly well formed, some broken, some noise, some cut short.
    task automatic build_body();
        int style;
        int keep;
        body_buf.delete();
        style = $urandom_range(0, 99);
        if (style < 6)
        begin
            repeat ($urandom_range(1, 12)) body_buf.push_back(8'($urandom()));
        end
        else if (style < 10)
        begin
            // Random declared size, usually much larger than the data that follows.
            put_size_line($urandom());
            repeat ($urandom_range(1, 10)) body_buf.push_back(8'($urandom()));
        end
        else
        begin
            repeat ($urandom_range(0, 4)) put_chunk();
            if (style < 22)
            begin
                put_bad_line();
                repeat ($urandom_range(0, 6)) body_buf.push_back(8'($urandom()));
            end
            else
            begin
                put_size_line(32'd0);
                if ($urandom_range(0, 3) != 0)
                    put_crlf();
            end
        end
        if (body_buf.size() > 1 && $urandom_range(0, 99) < 15)
        begin
            keep = $urandom_range(1, body_buf.size() - 1);
            while (body_buf.size() > keep)
                void'(body_buf.pop_back());
        end
    endtask

    // Moves the built body to the send queue, flagging its final byte.
    task automatic queue_body(input logic sync);
        foreach (body_buf[i])
            pending.push_back('{b: body_buf[i], fin: i == body_buf.size() - 1,
                                sync: sync && i == 0});
    endtask

    // Sender: offers the next byte once the current beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_gap   <= 0;
            rx_burst <= 0;
        end
        else if (!rx_valid || rx_ready)
        begin
            if (rx_valid)
            begin
                decode_byte(in_byte, body_end);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (rx_gap != 0)
            begin
                rx_gap   <= rx_gap - 1;
                rx_valid <= 1'b0;
            end
            else if (pending.size() == 0 || (pending[0].sync && decoded_due.size() != 0))
            begin
                rx_valid <= 1'b0;
            end
            else
            begin
                rx_valid <= 1'b1;
                in_byte  <= pending[0].b;
                body_end <= pending[0].fin;
                void'(pending.pop_front());
                if (rx_burst != 0)
                begin
                    rx_burst <= rx_burst - 1;
                    rx_gap   <= 0;
                end
                else
                begin
                    rx_gap <= idle_len();
                    if ($urandom_range(0, 19) == 0)
                        rx_burst <= $urandom_range(20, 80);
                end
            end
        end
    end

    // Receiver: random stalls, bursts of steady readiness, and one long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_ready  <= 1'b0;
            tx_wait   <= 0;
            tx_burst  <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            tx_wait   <= HOLD_LEN;
            tx_ready  <= 1'b0;
        end
        else if (tx_wait != 0)
        begin
            tx_wait  <= tx_wait - 1;
            tx_ready <= 1'b0;
        end
        else if (tx_burst != 0)
        begin
            tx_burst <= tx_burst - 1;
            tx_ready <= 1'b1;
        end
        else
        begin
            tx_ready <= 1'b1;
            tx_wait  <= idle_len();
            if ($urandom_range(0, 19) == 0)
                tx_burst <= $urandom_range(20, 80);
        end
    end

    // Checker: every output beat against the oldest expected beat.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && tx_valid && tx_ready)
        begin
            if (decoded_due.size() == 0)
            begin
                if (mismatches < SHOW_MAX)
                    $display("Unexpected beat: out_byte=%02h kind=%0d last=%0b",
                             out_byte, kind, last);
                mismatches++;
            end
            else
            begin
                want = decoded_due.pop_front();
                if (out_byte !== want.b || kind !== want.k || last !== want.l)
                begin
                    if (mismatches < SHOW_MAX)
                        $display("Beat mismatch: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                                 want.b, want.k, want.l, out_byte, kind, last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int bodies;
        reset_model();

        // Prefixed one-byte chunk with its CRLF, then a terminator given as a bare prefix.
        body_buf.delete();
        put_text("0x1");
        put_crlf();
        body_buf.push_back(8'hFF);
        put_crlf();
        put_text("0x");
        put_crlf();
        queue_body(1'b0);

        // An x after a nonzero digit is tail; the body ends on a data byte.
        body_buf.delete();
        put_text("1x");
        put_crlf();
        body_buf.push_back(8'h00);
        queue_body(1'b0);

        // Blank then CRLF with no digits.
        body_buf.delete();
        body_buf.push_back(CHAR_TAB);
        put_crlf();
        queue_body(1'b0);

        // Ninth digit overflows the size.
        body_buf.delete();
        put_text("F00000000");
        queue_body(1'b0);

        bodies = 0;
        while (pending.size() < RAND_BYTES + 30)
        begin
            build_body();
            bodies++;
            queue_body(bodies % 25 == 12);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || rx_valid)
            @(posedge clk);
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && decoded_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
